[hdl/lpp_pkg.sv]
// lpp_pkg: shared types, opcodes, mode codes and default sizes for the
// led pulse pattern player; no dependencies
`default_nettype none

package lpp_pkg;

  localparam int LED_COUNT_DEF      = 4;
  localparam int PATTERN_COUNT_DEF  = 8;
  localparam int PATTERN_LENGTH_DEF = 16;
  localparam int TICK_STEP_DEF      = 10;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_SET     = 3'd1;
  localparam logic [2:0] OP_TOGGLE  = 3'd2;
  localparam logic [2:0] OP_PULSE   = 3'd3;
  localparam logic [2:0] OP_PATTERN = 3'd4;
  localparam logic [2:0] OP_LOAD    = 3'd5;

  localparam logic [1:0] MODE_MANUAL  = 2'd0;
  localparam logic [1:0] MODE_PULSE   = 2'd1;
  localparam logic [1:0] MODE_PATTERN = 2'd2;

  localparam logic [15:0] FOREVER  = 16'hFFFF;
  localparam logic [7:0]  END_BYTE = 8'hFF;
  localparam logic [16:0] TIME_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  led_select;
    logic        level;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [15:0] repeat_count;
    logic [3:0]  pattern_select;
    logic [3:0]  pattern_slot;
    logic [7:0]  pattern_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] led_levels;
    logic [3:0] timed_active;
  } out_item_t;

  // per-led command for the transfer being processed
  typedef struct packed {
    logic        tick;
    logic        set_lvl;
    logic        toggle;
    logic        pulse_start;
    logic        pat_start;
    logic        pat_show;
    logic        pat_done;
    logic        level;
    logic        pat_bit;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [15:0] repeat_count;
  } lane_cmd_t;

  typedef struct packed {
    logic level;
    logic active;
  } lane_stat_t;

endpackage

`default_nettype wire

[hdl/lpp_pattern_mem.sv]
// lpp_pattern_mem: pattern byte store, one write port and two registered
// read ports with write forwarding; no package dependency
`default_nettype none

module lpp_pattern_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr0,
  input  wire logic [AW-1:0] rd_addr1,
  output logic      [7:0]    rd_data0,
  output logic      [7:0]    rd_data1
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // a byte loaded this cycle is forwarded to a read of the same address
    rd_data0 <= (wr_en && wr_addr == rd_addr0) ? wr_data : mem[rd_addr0];
    rd_data1 <= (wr_en && wr_addr == rd_addr1) ? wr_data : mem[rd_addr1];
  end

endmodule

`default_nettype wire

[hdl/lpp_led_lane.sv]
// lpp_led_lane: level, mode and pulse timer of one led
// depends on lpp_pkg
`default_nettype none

module lpp_led_lane
  import lpp_pkg::*;
#(
  parameter int TICK_STEP = TICK_STEP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lane_cmd_t  cmd,
  output lane_stat_t      stat_nxt
);

  logic        level_r,   level_nxt;
  logic [1:0]  mode_r,    mode_nxt;
  logic [16:0] elapsed_r, elapsed_nxt;
  logic [15:0] cycles_r,  cycles_nxt;
  logic [15:0] on_r,      on_nxt;
  logic [15:0] off_r,     off_nxt;
  logic [15:0] limit_r,   limit_nxt;

  logic [16:0] period;
  logic [17:0] t_sum;
  logic [15:0] cyc_inc;

  assign period  = {1'b0, on_r} + {1'b0, off_r};
  assign t_sum   = {1'b0, elapsed_r} + 18'(TICK_STEP);
  assign cyc_inc = cycles_r + ((limit_r != FOREVER) ? 16'd1 : 16'd0);

  always_comb begin
    level_nxt   = level_r;
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    cycles_nxt  = cycles_r;
    on_nxt      = on_r;
    off_nxt     = off_r;
    limit_nxt   = limit_r;
    if (cmd.set_lvl) begin
      level_nxt = cmd.level;
      mode_nxt  = MODE_MANUAL;
    end
    if (cmd.toggle) begin
      level_nxt = ~level_r;
      mode_nxt  = MODE_MANUAL;
    end
    if (cmd.pulse_start) begin
      on_nxt      = cmd.on_time;
      off_nxt     = cmd.off_time;
      limit_nxt   = cmd.repeat_count;
      elapsed_nxt = '0;
      cycles_nxt  = '0;
      mode_nxt    = MODE_PULSE;
    end
    if (cmd.pat_start) begin
      mode_nxt = MODE_PATTERN;
    end
    if (cmd.tick) begin
      case (mode_r)
        MODE_PULSE: begin
          level_nxt = (elapsed_r < {1'b0, on_r});
          if (elapsed_r >= period) begin
            cycles_nxt = cyc_inc;
            if (cyc_inc >= limit_r) begin
              level_nxt = 1'b0;
              mode_nxt  = MODE_MANUAL;
            end else begin
              elapsed_nxt = '0;
            end
          end else begin
            elapsed_nxt = (t_sum > {1'b0, TIME_MAX}) ? TIME_MAX : t_sum[16:0];
          end
        end
        MODE_PATTERN: begin
          if (cmd.pat_show) begin
            level_nxt = cmd.pat_bit;
          end
          if (cmd.pat_done) begin
            level_nxt = 1'b0;
            mode_nxt  = MODE_MANUAL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_nxt.level  = level_nxt;
  assign stat_nxt.active = (mode_nxt != MODE_MANUAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= 1'b0;
      mode_r    <= MODE_MANUAL;
      elapsed_r <= '0;
      cycles_r  <= '0;
      on_r      <= '0;
      off_r     <= '0;
      limit_r   <= '0;
    end else begin
      level_r   <= level_nxt;
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      cycles_r  <= cycles_nxt;
      on_r      <= on_nxt;
      off_r     <= off_nxt;
      limit_r   <= limit_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/led_pulse_pattern_player_unit.sv]
// led_pulse_pattern_player_unit: top level, input register, shared pattern
// sequencer, led lanes and result register
// depends on lpp_pkg, lpp_led_lane, lpp_pattern_mem
//
//   channel | ports                          | payload
//   input   | in_valid, in_ready, in_data    | in_item_t
//   result  | out_valid, out_ready, out_data | out_item_t
//
// one transfer in and one result out per cycle when neither side stalls;
// the path runs through the input register, then logic into the result register
// the pattern store is read through registered ports addressed from next state
// reset clears all led and sequencer state; pattern bytes are undefined until
// loaded and are not cleared
// a stalled result holds the item in the input register; no further item is taken
`default_nettype none

module led_pulse_pattern_player_unit
  import lpp_pkg::*;
#(
  parameter int LED_COUNT      = LED_COUNT_DEF,
  parameter int PATTERN_COUNT  = PATTERN_COUNT_DEF,
  parameter int PATTERN_LENGTH = PATTERN_LENGTH_DEF,
  parameter int TICK_STEP      = TICK_STEP_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int DEPTH = PATTERN_COUNT * PATTERN_LENGTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
  localparam int SW    = $clog2(PATTERN_LENGTH);

  in_item_t   item_r;
  logic       item_v_r;
  out_item_t  res_r;
  logic       res_v_r;
  logic       fire;

  assign fire      = item_v_r && (!res_v_r || out_ready);
  assign in_ready  = !item_v_r || fire;
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  // shared pattern sequencer
  logic [PW-1:0] pp_r,     pp_nxt;
  logic [SW-1:0] step_r,   step_nxt;
  logic [16:0]   pel_r,    pel_nxt;
  logic [15:0]   pcyc_r,   pcyc_nxt;
  logic [15:0]   pon_r,    pon_nxt;
  logic [15:0]   plim_r,   plim_nxt;

  logic [7:0]    rd_cur, rd_next;
  logic [AW-1:0] rd_addr_cur, rd_addr_next, wr_addr;
  logic          wr_en;

  logic op_tick, op_set, op_toggle, op_pulse, op_pattern;
  logic pat_ok, load_ok, sel_all;
  logic pat_show, pat_done;
  logic [17:0]   pel_sum;
  logic [16:0]   pel_sat;
  logic [SW:0]   step_inc;
  logic [15:0]   pcyc_inc;

  assign op_tick    = fire && item_r.opcode == OP_TICK;
  assign op_set     = fire && item_r.opcode == OP_SET;
  assign op_toggle  = fire && item_r.opcode == OP_TOGGLE;
  assign op_pulse   = fire && item_r.opcode == OP_PULSE;
  assign op_pattern = fire && item_r.opcode == OP_PATTERN &&
                      ({1'b0, item_r.pattern_select} < 5'(PATTERN_COUNT));
  assign pat_ok     = {1'b0, item_r.pattern_select} < 5'(PATTERN_COUNT);
  assign load_ok    = pat_ok && ({3'b000, item_r.pattern_slot} < 7'(PATTERN_LENGTH));
  assign wr_en      = fire && item_r.opcode == OP_LOAD && load_ok;
  assign wr_addr    = AW'(32'(item_r.pattern_select) * PATTERN_LENGTH +
                          32'(item_r.pattern_slot));
  assign sel_all    = ({1'b0, item_r.led_select} == 4'(LED_COUNT));

  assign pel_sum  = {1'b0, pel_r} + 18'(TICK_STEP);
  assign pel_sat  = (pel_sum > {1'b0, TIME_MAX}) ? TIME_MAX : pel_sum[16:0];
  assign step_inc = {1'b0, step_r} + 1'b1;
  assign pcyc_inc = pcyc_r + ((plim_r != FOREVER) ? 16'd1 : 16'd0);
  assign pat_show = (pel_r == '0);

  always_comb begin
    pp_nxt   = pp_r;
    step_nxt = step_r;
    pel_nxt  = pel_r;
    pcyc_nxt = pcyc_r;
    pon_nxt  = pon_r;
    plim_nxt = plim_r;
    pat_done = 1'b0;
    if (op_pattern) begin
      pp_nxt   = PW'(item_r.pattern_select);
      step_nxt = '0;
      pel_nxt  = '0;
      pcyc_nxt = '0;
      pon_nxt  = item_r.on_time;
      plim_nxt = item_r.repeat_count;
    end
    if (op_tick) begin
      pel_nxt = pel_sat;
      if (pel_sat > {1'b0, pon_r}) begin
        pel_nxt = '0;
        if (step_inc < (SW+1)'(PATTERN_LENGTH) && rd_next != END_BYTE) begin
          step_nxt = step_inc[SW-1:0];
        end else begin
          // end of pattern: count one repeat unless the limit is FOREVER
          step_nxt = '0;
          pcyc_nxt = pcyc_inc;
          pat_done = (pcyc_inc >= plim_r);
        end
      end
    end
  end

  // read addresses follow the next state so data is ready for the next item
  assign rd_addr_cur  = AW'(32'(pp_nxt) * PATTERN_LENGTH + 32'(step_nxt));
  assign rd_addr_next = AW'(32'(pp_nxt) * PATTERN_LENGTH + 32'(step_nxt) + 1);

  lpp_pattern_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (item_r.pattern_byte),
    .rd_addr0 (rd_addr_cur),
    .rd_addr1 (rd_addr_next),
    .rd_data0 (rd_cur),
    .rd_data1 (rd_next)
  );

  lane_cmd_t  cmd  [LED_COUNT];
  lane_stat_t stat [LED_COUNT];

  for (genvar n = 0; n < LED_COUNT; n++) begin : g_lane
    logic hit;
    assign hit = sel_all || (item_r.led_select == 3'(n));

    assign cmd[n].tick         = op_tick;
    assign cmd[n].set_lvl      = op_set && hit;
    assign cmd[n].toggle       = op_toggle && hit;
    assign cmd[n].pulse_start  = op_pulse && hit;
    assign cmd[n].pat_start    = op_pattern;
    assign cmd[n].pat_show     = pat_show;
    assign cmd[n].pat_done     = pat_done;
    assign cmd[n].level        = item_r.level;
    assign cmd[n].pat_bit      = rd_cur[n];
    assign cmd[n].on_time      = item_r.on_time;
    assign cmd[n].off_time     = item_r.off_time;
    assign cmd[n].repeat_count = item_r.repeat_count;

    lpp_led_lane #(
      .TICK_STEP (TICK_STEP)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd[n]),
      .stat_nxt (stat[n])
    );
  end

  out_item_t res_nxt;

  always_comb begin
    res_nxt = '0;
    for (int n = 0; n < LED_COUNT; n++) begin
      if (n < 4) begin
        res_nxt.led_levels[n]   = stat[n].level;
        res_nxt.timed_active[n] = stat[n].active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      res_v_r  <= 1'b0;
      pp_r     <= '0;
      step_r   <= '0;
      pel_r    <= '0;
      pcyc_r   <= '0;
      pon_r    <= '0;
      plim_r   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        item_v_r <= 1'b1;
      end else if (fire) begin
        item_v_r <= 1'b0;
      end
      if (fire) begin
        res_v_r <= 1'b1;
      end else if (out_ready) begin
        res_v_r <= 1'b0;
      end
      pp_r   <= pp_nxt;
      step_r <= step_nxt;
      pel_r  <= pel_nxt;
      pcyc_r <= pcyc_nxt;
      pon_r  <= pon_nxt;
      plim_r <= plim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && res_v_r && !out_ready) |-> !in_ready)
    else $error("input taken while item and result are both held");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> res_v_r)
    else $error("processed item produced no result");

  a_pattern_time_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pel_r <= {1'b0, pon_r})
    else $error("pattern sample time passed its duration");

  a_pattern_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pp_r) < PATTERN_COUNT)
    else $error("playing pattern out of range");

  a_reset_clears_result: assert property (@(posedge clk)
    !rst_n |=> !res_v_r && !item_v_r)
    else $error("valid state survived reset");
`endif

endmodule

`default_nettype wire
